### sv/bam_pkg.sv
`timescale 1ns / 1ps

package bam_pkg;

   localparam int RegCount = 8;
   localparam int RegIdxW = 3;
   localparam int WordW = 16;
   localparam int ByteW = 8;

   // item opcodes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_REPLY = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_REQ      = 2'd0;
   localparam logic [1:0] KIND_DONE     = 2'd1;
   localparam logic [1:0] KIND_FAIL     = 2'd2;
   localparam logic [1:0] KIND_READBACK = 2'd3;

   // fetch phases
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_FIRST = 2'd1;
   localparam logic [1:0] PH_DEFER = 2'd2;
   localparam logic [1:0] PH_DATA  = 2'd3;

   // addressing modes
   localparam logic [2:0] MODE_REG      = 3'd0;
   localparam logic [2:0] MODE_DEF      = 3'd1;
   localparam logic [2:0] MODE_AINC     = 3'd2;
   localparam logic [2:0] MODE_AINC_DEF = 3'd3;
   localparam logic [2:0] MODE_ADEC     = 3'd4;
   localparam logic [2:0] MODE_ADEC_DEF = 3'd5;
   localparam logic [2:0] MODE_IDX      = 3'd6;
   localparam logic [2:0] MODE_IDX_DEF  = 3'd7;

   localparam logic [RegIdxW-1:0] REG_SP = 3'd6;
   localparam logic [RegIdxW-1:0] REG_PC = 3'd7;

   localparam logic [WordW-1:0] WORD_STEP = 16'd2;
   localparam logic [WordW-1:0] ADDR_MASK = 16'hFFFE;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [RegIdxW-1:0] reg_index;
      logic [WordW-1:0]   reg_value;
      logic [2:0]         mode;
      logic               update_registers;
      logic [WordW-1:0]   read_data;
      logic               read_ok;
   } item_type;

   typedef struct packed {
      logic               en;
      logic [RegIdxW-1:0] index;
      logic [WordW-1:0]   data;
   } reg_wr_type;

   typedef struct packed {
      logic [1:0]       result_kind;
      logic [WordW-1:0] read_address;
      logic [ByteW-1:0] byte_value;
      logic [WordW-1:0] register_contents;
   } result_type;

   // autoincrement / autodecrement step: two for sp and pc, one otherwise
   function automatic logic [WordW-1:0] step_size(input logic [RegIdxW-1:0] r);
      logic [WordW-1:0] s;
      s = (r == REG_SP || r == REG_PC) ? WORD_STEP : 16'd1;
      return s;
   endfunction

endpackage

### sv/bam_regfile.sv
`timescale 1ns / 1ps

module bam_regfile
   import bam_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  reg_wr_type          wr,
   input  logic [RegIdxW-1:0]  rd_index,
   output logic [WordW-1:0]    rd_data,
   output logic [WordW-1:0]    pc_data
);

   logic [WordW-1:0] regs_ff [RegCount];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RegCount; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (wr.en) begin
         regs_ff[wr.index] <= wr.data;
      end
   end

   assign rd_data = regs_ff[rd_index];
   assign pc_data = regs_ff[REG_PC];

endmodule

### sv/bam_fetch_ctl.sv
`timescale 1ns / 1ps

module bam_fetch_ctl
   import bam_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  item_type            item,
   input  logic [WordW-1:0]    rd_data,
   input  logic [WordW-1:0]    pc_data,
   output logic [RegIdxW-1:0]  rd_index,
   output reg_wr_type          wr,
   output logic                res_valid,
   output result_type          res
);

   logic [1:0]         phase_ff, phase_in;
   logic [2:0]         mode_ff, mode_in;
   logic [RegIdxW-1:0] ridx_ff, ridx_in;
   logic               hi_ff, hi_in;
   logic               upd_ff, upd_in;

   logic [WordW-1:0] addr;
   logic [WordW-1:0] idx_base;
   reg_wr_type       wr_c;

   assign rd_index = (item.opcode == OP_REPLY) ? ridx_ff : item.reg_index;

   // pc as base register sees the index word already skipped
   assign idx_base = rd_data + ((ridx_ff == REG_PC) ? WORD_STEP : '0);

   always_comb begin
      phase_in  = phase_ff;
      mode_in   = mode_ff;
      ridx_in   = ridx_ff;
      hi_in     = hi_ff;
      upd_in    = upd_ff;
      wr_c      = '0;
      res_valid = 1'b0;
      res       = '0;
      addr      = '0;

      case (item.opcode)
         OP_WRITE: begin
            wr_c.en    = 1'b1;
            wr_c.index = item.reg_index;
            wr_c.data  = item.reg_value;
         end
         OP_READ: begin
            res_valid             = 1'b1;
            res.result_kind       = KIND_READBACK;
            res.register_contents = rd_data;
         end
         OP_START: begin
            mode_in    = item.mode;
            ridx_in    = item.reg_index;
            upd_in     = item.update_registers;
            res_valid  = 1'b1;
            wr_c.index = item.reg_index;
            case (item.mode)
               MODE_REG: begin
                  phase_in       = PH_IDLE;
                  res.result_kind = KIND_DONE;
                  res.byte_value = rd_data[ByteW-1:0];
               end
               MODE_DEF: begin
                  addr     = rd_data;
                  phase_in = PH_DATA;
               end
               MODE_AINC: begin
                  addr      = rd_data;
                  wr_c.en   = item.update_registers;
                  wr_c.data = rd_data + step_size(item.reg_index);
                  phase_in  = PH_DATA;
               end
               MODE_AINC_DEF: begin
                  addr      = rd_data;
                  wr_c.en   = item.update_registers;
                  wr_c.data = rd_data + WORD_STEP;
                  phase_in  = PH_FIRST;
               end
               MODE_ADEC: begin
                  addr      = rd_data - step_size(item.reg_index);
                  wr_c.en   = item.update_registers;
                  wr_c.data = addr;
                  phase_in  = PH_DATA;
               end
               MODE_ADEC_DEF: begin
                  addr      = rd_data - WORD_STEP;
                  wr_c.en   = item.update_registers;
                  wr_c.data = addr;
                  phase_in  = PH_FIRST;
               end
               default: begin
                  addr     = pc_data;
                  phase_in = PH_FIRST;
               end
            endcase
            if (item.mode != MODE_REG) begin
               res.result_kind  = KIND_REQ;
               res.read_address = addr & ADDR_MASK;
               if (phase_in == PH_DATA) begin
                  hi_in = addr[0];
               end
            end
         end
         default: begin
            // memory reply
            if (phase_ff != PH_IDLE) begin
               res_valid = 1'b1;
               if (!item.read_ok) begin
                  phase_in        = PH_IDLE;
                  res.result_kind = KIND_FAIL;
               end else begin
                  case (phase_ff)
                     PH_DATA: begin
                        phase_in        = PH_IDLE;
                        res.result_kind = KIND_DONE;
                        res.byte_value  = hi_ff ? item.read_data[WordW-1:ByteW]
                                                : item.read_data[ByteW-1:0];
                     end
                     PH_DEFER: begin
                        addr     = item.read_data;
                        phase_in = PH_DATA;
                     end
                     default: begin
                        if (mode_ff inside {MODE_AINC_DEF, MODE_ADEC_DEF}) begin
                           addr     = item.read_data;
                           phase_in = PH_DATA;
                        end else begin
                           addr       = item.read_data + idx_base;
                           wr_c.en    = upd_ff;
                           wr_c.index = REG_PC;
                           wr_c.data  = pc_data + WORD_STEP;
                           phase_in   = (mode_ff == MODE_IDX) ? PH_DATA : PH_DEFER;
                        end
                     end
                  endcase
                  if (phase_ff != PH_DATA) begin
                     res.result_kind  = KIND_REQ;
                     res.read_address = addr & ADDR_MASK;
                     if (phase_in == PH_DATA) begin
                        hi_in = addr[0];
                     end
                  end
               end
            end
         end
      endcase
   end

   assign wr = '{en: wr_c.en & fire, index: wr_c.index, data: wr_c.data};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         mode_ff  <= '0;
         ridx_ff  <= '0;
         hi_ff    <= 1'b0;
         upd_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         mode_ff  <= mode_in;
         ridx_ff  <= ridx_in;
         hi_ff    <= hi_in;
         upd_ff   <= upd_in;
      end
   end

endmodule

### sv/byte_operand_address_mode_fetch_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// req_*     in         req_valid / req_stall     opcode, reg_index, reg_value, mode,
//                                                update_registers, read_data, read_ok
// rsp_*     out        rsp_valid / rsp_stall     result_kind, read_address, byte_value,
//                                                register_contents
//
// every item goes from transfer into the input register, then through the mode logic
// into the result register; one item per cycle sustained while rsp_stall stays low
// reset clears the register file to zero and the fetch sequencer to idle
// a stalled result holds in the result register; the input register still drains
// into it in the cycle the result is taken, so rsp_stall backs up to req_stall
// items that give no result (register writes, replies while idle) still wait for a free result register

module byte_operand_address_mode_fetch_top
   import bam_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // item channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_opcode,
   input  logic [RegIdxW-1:0]  req_reg_index,
   input  logic [WordW-1:0]    req_reg_value,
   input  logic [2:0]          req_mode,
   input  logic                req_update_registers,
   input  logic [WordW-1:0]    req_read_data,
   input  logic                req_read_ok,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_result_kind,
   output logic [WordW-1:0]    rsp_read_address,
   output logic [ByteW-1:0]    rsp_byte_value,
   output logic [WordW-1:0]    rsp_register_contents
);

   // input register
   logic     in_valid_ff, in_valid_in;
   item_type item_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   logic               out_free;
   logic               fire;
   logic               req_xfer;
   logic [RegIdxW-1:0] rd_index;
   logic [WordW-1:0]   rd_data;
   logic [WordW-1:0]   pc_data;
   reg_wr_type         wr;
   logic               res_valid;
   result_type         res;

   // result register can take a new value when empty or being emptied this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_xfer  = req_valid && !req_stall;

   assign in_valid_in  = req_xfer || (in_valid_ff && !fire);
   assign out_valid_in = fire ? res_valid : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= '{opcode: req_opcode, reg_index: req_reg_index,
                      reg_value: req_reg_value, mode: req_mode,
                      update_registers: req_update_registers,
                      read_data: req_read_data, read_ok: req_read_ok};
      end
      if (fire && res_valid) begin
         out_ff <= res;
      end
   end

   bam_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd_index (rd_index),
      .rd_data  (rd_data),
      .pc_data  (pc_data)
   );

   // mode decode, address arithmetic and fetch sequencing
   bam_fetch_ctl u_fetch_ctl (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item_ff),
      .rd_data   (rd_data),
      .pc_data   (pc_data),
      .rd_index  (rd_index),
      .wr        (wr),
      .res_valid (res_valid),
      .res       (res)
   );

   assign rsp_valid             = out_valid_ff;
   assign rsp_result_kind       = out_ff.result_kind;
   assign rsp_read_address      = out_ff.read_address;
   assign rsp_byte_value        = out_ff.byte_value;
   assign rsp_register_contents = out_ff.register_contents;

   // stall only ever comes from a held item in the input register
   a_stall_has_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall without a held item");

   // memory requests are word aligned
   a_req_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_REQ |-> !rsp_read_address[0])
      else $error("odd request address");

   // byte value only carried by a finished operand
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_DONE |-> rsp_byte_value == '0)
      else $error("stray byte value");

   // register contents only carried by a readback
   a_contents_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_READBACK |-> rsp_register_contents == '0)
      else $error("stray register contents");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb
   import bam_pkg::*;
();

   // generous ceiling: ~450 items at worst gap plus worst stall plus the long hold
   localparam int unsigned CycleLimit = 200000;
   localparam int TailCycles = 20;
   localparam int IdleMax = 19;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_opcode;
   logic [RegIdxW-1:0] req_reg_index;
   logic [WordW-1:0]   req_reg_value;
   logic [2:0]         req_mode;
   logic               req_update_registers;
   logic [WordW-1:0]   req_read_data;
   logic               req_read_ok;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_result_kind;
   logic [WordW-1:0]   rsp_read_address;
   logic [ByteW-1:0]   rsp_byte_value;
   logic [WordW-1:0]   rsp_register_contents;

   // sender / receiver pacing, changed by the tests
   int gap_max = IdleMax;
   int stall_max = IdleMax;
   int hold_off_cycles = 0;

   int unsigned sent_items = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;

   // expected results in transfer order
   result_type pending_results[$];

   // shadow of the block: register file and fetch sequencer
   logic [WordW-1:0]   gpr [RegCount];
   logic [1:0]         seq_phase;
   logic [2:0]         held_mode;
   logic [RegIdxW-1:0] held_reg;
   logic               held_hi;
   logic               held_upd;

   byte_operand_address_mode_fetch_top dut (.*);

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   // word request; bit 0 of the address is always dropped
   function automatic result_type read_request(input logic [WordW-1:0] addr,
                                               input logic [1:0] next_phase);
      result_type r;
      r = '0;
      r.result_kind = KIND_REQ;
      r.read_address = addr & ADDR_MASK;
      seq_phase = next_phase;
      return r;
   endfunction

   // byte request remembers which half of the word to take
   function automatic result_type byte_request(input logic [WordW-1:0] addr);
      held_hi = addr[0];
      return read_request(addr, PH_DATA);
   endfunction

   // advances the shadow by one transfer; returns 1 when the item gives a result
   function automatic bit predict_fetch_result(input item_type it, output result_type res);
      logic [RegIdxW-1:0] ri;
      logic [WordW-1:0]   a;
      logic [WordW-1:0]   bump;
      res = '0;
      ri = it.reg_index;
      bump = (ri == REG_SP || ri == REG_PC) ? WORD_STEP : 16'd1;
      case (it.opcode)
         OP_WRITE: begin
            gpr[ri] = it.reg_value;
            return 1'b0;
         end
         OP_READ: begin
            res.result_kind = KIND_READBACK;
            res.register_contents = gpr[ri];
            return 1'b1;
         end
         OP_START: begin
            // a new start drops whatever was pending
            held_mode = it.mode;
            held_reg = ri;
            held_upd = it.update_registers;
            seq_phase = PH_IDLE;
            case (it.mode)
               MODE_REG: begin
                  res.result_kind = KIND_DONE;
                  res.byte_value = gpr[ri][7:0];
               end
               MODE_DEF: res = byte_request(gpr[ri]);
               MODE_AINC: begin
                  a = gpr[ri];
                  if (held_upd) gpr[ri] = a + bump;
                  res = byte_request(a);
               end
               MODE_AINC_DEF: begin
                  a = gpr[ri];
                  if (held_upd) gpr[ri] = a + WORD_STEP;
                  res = read_request(a, PH_FIRST);
               end
               MODE_ADEC: begin
                  a = gpr[ri] - bump;
                  if (held_upd) gpr[ri] = a;
                  res = byte_request(a);
               end
               MODE_ADEC_DEF: begin
                  a = gpr[ri] - WORD_STEP;
                  if (held_upd) gpr[ri] = a;
                  res = read_request(a, PH_FIRST);
               end
               default: res = read_request(gpr[REG_PC], PH_FIRST);
            endcase
            return 1'b1;
         end
         default: begin
            // memory reply
            if (seq_phase == PH_IDLE) return 1'b0;
            if (!it.read_ok) begin
               seq_phase = PH_IDLE;
               res.result_kind = KIND_FAIL;
               return 1'b1;
            end
            case (seq_phase)
               PH_DATA: begin
                  seq_phase = PH_IDLE;
                  res.result_kind = KIND_DONE;
                  res.byte_value = held_hi ? it.read_data[15:8] : it.read_data[7:0];
               end
               PH_DEFER: res = byte_request(it.read_data);
               default: begin
                  if (held_mode == MODE_AINC_DEF || held_mode == MODE_ADEC_DEF) begin
                     res = byte_request(it.read_data);
                  end else begin
                     // index word: pc advance, or +2 on the index when pc is the base
                     a = it.read_data;
                     if (held_upd) gpr[REG_PC] = gpr[REG_PC] + WORD_STEP;
                     else if (held_reg == REG_PC) a = a + WORD_STEP;
                     a = a + gpr[held_reg];
                     if (held_mode == MODE_IDX) res = byte_request(a);
                     else res = read_request(a, PH_DEFER);
                  end
               end
            endcase
            return 1'b1;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input result_type got,
                                  input result_type want);
      mismatches++;
      if (mismatches <= 50)
         $display("%0t %0s: got kind %0d addr %h byte %h reg %h,",
                  $realtime, what, got.result_kind, got.read_address, got.byte_value,
                  got.register_contents,
                  " want kind %0d addr %h byte %h reg %h",
                  want.result_kind, want.read_address,
                  want.byte_value, want.register_contents);
   endtask

   // predicts on each input transfer, then checks the result transfer of the same edge
   always @(posedge clock) begin : result_check
      item_type   seen;
      result_type got;
      result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen.opcode = req_opcode;
            seen.reg_index = req_reg_index;
            seen.reg_value = req_reg_value;
            seen.mode = req_mode;
            seen.update_registers = req_update_registers;
            seen.read_data = req_read_data;
            seen.read_ok = req_read_ok;
            if (predict_fetch_result(seen, want)) pending_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got.result_kind = rsp_result_kind;
            got.read_address = rsp_read_address;
            got.byte_value = rsp_byte_value;
            got.register_contents = rsp_register_contents;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", got, '0);
            end else begin
               want = pending_results.pop_front();
               if (got.result_kind !== want.result_kind
                   || got.read_address !== want.read_address
                   || got.byte_value !== want.byte_value
                   || got.register_contents !== want.register_contents)
                  report_mismatch("wrong result", got, want);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // result side: random stall before each transfer, or one long hold on request
   // ---------------------------------------------------------------------------

   initial begin : result_sink
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            n = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            n = $urandom_range(0, stall_max);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------

   // random gap, then hold the item until it transfers; valid stays up when no gap
   task automatic offer_item(input item_type it);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= it.opcode;
      req_reg_index <= it.reg_index;
      req_reg_value <= it.reg_value;
      req_mode <= it.mode;
      req_update_registers <= it.update_registers;
      req_read_data <= it.read_data;
      req_read_ok <= it.read_ok;
      do @(posedge clock); while (req_stall);
      sent_items++;
   endtask

   task automatic offer(input logic [1:0] op, input logic [RegIdxW-1:0] ri,
                        input logic [WordW-1:0] value, input logic [2:0] mode,
                        input logic upd, input logic [WordW-1:0] data, input logic ok);
      item_type it;
      it.opcode = op;
      it.reg_index = ri;
      it.reg_value = value;
      it.mode = mode;
      it.update_registers = upd;
      it.read_data = data;
      it.read_ok = ok;
      offer_item(it);
   endtask

   function automatic item_type random_item();
      item_type it;
      it.opcode = 2'($urandom_range(0, 3));
      it.reg_index = RegIdxW'($urandom_range(0, RegCount - 1));
      it.reg_value = WordW'($urandom);
      it.mode = 3'($urandom_range(0, 7));
      it.update_registers = 1'($urandom_range(0, 1));
      it.read_data = WordW'($urandom);
      it.read_ok = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // register values biased toward the wrap points
   function automatic logic [WordW-1:0] pick_word();
      case ($urandom_range(0, 11))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h0001;
         3: return 16'hFFFE;
         4: return 16'h8000;
         5: return 16'h7FFF;
         default: return WordW'($urandom);
      endcase
   endfunction

   task automatic test_register_access();
      offer(OP_READ, 3'd0, '0, '0, 1'b0, '0, 1'b0);          // zero after reset
      offer(OP_WRITE, REG_PC, 16'hFFFF, '0, 1'b0, '0, 1'b0);
      offer(OP_WRITE, 3'd0, 16'h0000, '0, 1'b0, '0, 1'b0);
      offer(OP_WRITE, 3'd3, 16'h8001, '0, 1'b0, '0, 1'b0);
      offer(OP_WRITE, REG_SP, 16'h0001, '0, 1'b0, '0, 1'b0);
      offer(OP_READ, REG_PC, '0, '0, 1'b0, '0, 1'b0);
      offer(OP_READ, 3'd3, '0, '0, 1'b0, '0, 1'b0);
   endtask

   task automatic test_addressing_modes();
      // register mode, no memory traffic
      offer(OP_START, REG_PC, '0, MODE_REG, 1'b1, '0, 1'b0);
      // deferred through an odd address picks the high byte
      offer(OP_START, 3'd3, '0, MODE_DEF, 1'b0, '0, 1'b0);
      offer(OP_REPLY, '0, '0, '0, 1'b0, 16'h12AB, 1'b1);
      // autoincrement of sp steps by two, then the data read fails
      offer(OP_START, REG_SP, '0, MODE_AINC, 1'b1, '0, 1'b0);
      offer(OP_REPLY, '0, '0, '0, 1'b0, 16'hFFFF, 1'b0);
      // autodecrement from zero wraps to ffff
      offer(OP_START, 3'd0, '0, MODE_ADEC, 1'b1, '0, 1'b0);
      offer(OP_REPLY, '0, '0, '0, 1'b0, 16'h3400, 1'b1);
      // start while busy drops the first fetch
      offer(OP_START, REG_PC, '0, MODE_AINC_DEF, 1'b0, '0, 1'b0);
      offer(OP_START, REG_SP, '0, MODE_ADEC_DEF, 1'b1, '0, 1'b0);
      offer(OP_REPLY, '0, '0, '0, 1'b0, 16'h0005, 1'b1);
      offer(OP_REPLY, '0, '0, '0, 1'b0, 16'h7700, 1'b1);
      // reply while idle is ignored
      offer(OP_REPLY, '0, '0, '0, 1'b0, 16'hAAAA, 1'b1);
      // index deferred on pc without update; pc rewritten mid fetch
      offer(OP_START, REG_PC, '0, MODE_IDX_DEF, 1'b0, '0, 1'b0);
      offer(OP_WRITE, REG_PC, 16'h0100, '0, 1'b0, '0, 1'b0);
      offer(OP_REPLY, '0, '0, '0, 1'b0, 16'h00FF, 1'b1);
      offer(OP_REPLY, '0, '0, '0, 1'b0, 16'h1235, 1'b1);
      offer(OP_REPLY, '0, '0, '0, 1'b0, 16'hBEEF, 1'b1);
      // failed index word leaves pc alone
      offer(OP_START, 3'd2, '0, MODE_IDX, 1'b1, '0, 1'b0);
      offer(OP_REPLY, '0, '0, '0, 1'b0, 16'h0010, 1'b0);
      offer(OP_READ, REG_PC, '0, '0, 1'b0, '0, 1'b0);
   endtask

   // mostly complete fetches with random content; some writes, reads, strays and aborts
   task automatic run_random_traffic(input int unsigned count);
      item_type    it;
      int          pick;
      int          replies;
      int          k;
      int unsigned stop_at;
      stop_at = sent_items + count;
      while (sent_items < stop_at) begin
         it = random_item();
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            it.opcode = OP_WRITE;
            it.reg_value = pick_word();
            offer_item(it);
         end else if (pick < 16) begin
            it.opcode = OP_READ;
            offer_item(it);
         end else if (pick < 19) begin
            it.opcode = OP_REPLY;          // stray reply, nothing pending unless a fetch was abandoned
            offer_item(it);
         end else begin
            it.opcode = OP_START;
            offer_item(it);
            case (it.mode)
               MODE_REG: replies = 0;
               MODE_DEF, MODE_AINC, MODE_ADEC: replies = 1;
               MODE_IDX_DEF: replies = 3;
               default: replies = 2;
            endcase
            for (k = 0; k < replies; k++) begin
               it = random_item();
               pick = $urandom_range(0, 99);
               if (pick < 4) break;        // abandon; next start lands mid fetch
               if (pick < 10) begin
                  // register access slipped into the middle of a fetch
                  it.opcode = (pick < 7) ? OP_WRITE : OP_READ;
                  it.reg_value = pick_word();
                  offer_item(it);
                  it = random_item();
               end
               it.opcode = OP_REPLY;
               it.read_ok = ($urandom_range(0, 11) != 0);
               offer_item(it);
               if (!it.read_ok) break;
            end
         end
      end
   endtask

   task automatic test_random_fetches();
      run_random_traffic(300);
   endtask

   // no gaps and no stalls at all
   task automatic test_back_to_back();
      gap_max = 0;
      stall_max = 0;
      run_random_traffic(60);
      gap_max = IdleMax;
      stall_max = IdleMax;
   endtask

   // result side holds off while the sender keeps offering, so the input backs up
   task automatic test_full_pipeline();
      item_type it;
      int       k;
      gap_max = 0;
      hold_off_cycles = 150;
      for (k = 0; k < 16; k++) begin
         it = random_item();
         it.opcode = (k % 4 == 3) ? OP_WRITE : OP_READ;
         offer_item(it);
      end
      gap_max = IdleMax;
   endtask

   initial begin
      foreach (gpr[i]) gpr[i] = '0;
      seq_phase = PH_IDLE;
      held_mode = '0;
      held_reg = '0;
      held_hi = 1'b0;
      held_upd = 1'b0;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= OP_WRITE;
      req_reg_index <= '0;
      req_reg_value <= '0;
      req_mode <= '0;
      req_update_registers <= 1'b0;
      req_read_data <= '0;
      req_read_ok <= 1'b0;
      rsp_stall <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_register_access();
      test_addressing_modes();
      test_random_fetches();
      test_back_to_back();
      test_full_pipeline();
      req_valid <= 1'b0;

      // drain, then a short tail to catch stray results
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
